FILE: rtl/dihu_pkg.sv
// shared types, instruction kind codes and hazard helper functions
// for the dual-issue packing and hazard unit; no dependencies
package dihu_pkg;

  localparam int unsigned PC_BITS = 32;

  localparam logic [3:0] K_NOP      = 4'd0;
  localparam logic [3:0] K_RTYPE    = 4'd1;
  localparam logic [3:0] K_ITYPE    = 4'd2;
  localparam logic [3:0] K_LOAD     = 4'd3;
  localparam logic [3:0] K_STORE    = 4'd4;
  localparam logic [3:0] K_BRANCH   = 4'd5;
  localparam logic [3:0] K_JUMP     = 4'd6;
  localparam logic [3:0] K_SPECIAL  = 4'd7;
  localparam logic [3:0] K_JREG     = 4'd8;
  localparam logic [3:0] K_SQUASHED = 4'd9;

  // fall-through distance between a branch and its successor
  localparam logic [PC_BITS-1:0] BRANCH_STEP = PC_BITS'(4);

  typedef struct packed {
    logic [3:0]         kind;
    logic [PC_BITS-1:0] pc;
    logic [7:0]         src_a;
    logic [7:0]         src_b;
    logic [7:0]         dest;
  } slot_t;

  localparam slot_t NOP_SLOT = '{kind: K_NOP, pc: '0, src_a: '0, src_b: '0, dest: '0};
  localparam slot_t SQUASH_SLOT = '{kind: K_SQUASHED, pc: '0, src_a: '0, src_b: '0,
                                    dest: '0};

  function automatic logic is_mem(input slot_t s);
    return (s.kind == K_LOAD) || (s.kind == K_STORE);
  endfunction

  function automatic logic is_jump(input slot_t s);
    return (s.kind == K_JUMP) || (s.kind == K_JREG);
  endfunction

  function automatic logic reads_reg(input slot_t x, input logic [7:0] r);
    logic via_a;
    logic via_b;
    via_a = (x.src_a == r) && (x.kind != K_JUMP) && (x.kind != K_SPECIAL) &&
            (x.kind != K_SQUASHED);
    via_b = (x.src_b == r) &&
            ((x.kind == K_RTYPE) || (x.kind == K_STORE) || (x.kind == K_BRANCH));
    return via_a || via_b;
  endfunction

  function automatic logic pair_hazard(input slot_t lead, input slot_t x);
    logic writes;
    writes = (lead.kind == K_LOAD) || (lead.kind == K_RTYPE) || (lead.kind == K_ITYPE);
    return writes && reads_reg(x, lead.dest);
  endfunction

  function automatic logic load_use(input slot_t ld, input slot_t x);
    return (ld.kind == K_LOAD) && reads_reg(x, ld.dest);
  endfunction

endpackage

FILE: rtl/dihu_if.sv
// channel interfaces: offered instruction pair in, issued pair out
// depends on dihu_pkg
interface dihu_in_if import dihu_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [3:0]  first_kind;
  logic [31:0] first_pc;
  logic [7:0]  first_src_a;
  logic [7:0]  first_src_b;
  logic [7:0]  first_dest;
  logic [3:0]  second_kind;
  logic [31:0] second_pc;
  logic [7:0]  second_src_a;
  logic [7:0]  second_src_b;
  logic [7:0]  second_dest;

  modport source (
    output valid, first_kind, first_pc, first_src_a, first_src_b, first_dest,
           second_kind, second_pc, second_src_a, second_src_b, second_dest,
    input  ready
  );
  modport sink (
    input  valid, first_kind, first_pc, first_src_a, first_src_b, first_dest,
           second_kind, second_pc, second_src_a, second_src_b, second_dest,
    output ready
  );
endinterface

interface dihu_out_if import dihu_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [3:0]  alu_slot_kind;
  logic [31:0] alu_slot_pc;
  logic [7:0]  alu_slot_src_a;
  logic [7:0]  alu_slot_src_b;
  logic [7:0]  alu_slot_dest;
  logic [3:0]  mem_slot_kind;
  logic [31:0] mem_slot_pc;
  logic [7:0]  mem_slot_src_a;
  logic [7:0]  mem_slot_src_b;
  logic [7:0]  mem_slot_dest;
  logic [1:0]  consumed;

  modport source (
    output valid, alu_slot_kind, alu_slot_pc, alu_slot_src_a, alu_slot_src_b,
           alu_slot_dest, mem_slot_kind, mem_slot_pc, mem_slot_src_a,
           mem_slot_src_b, mem_slot_dest, consumed,
    input  ready
  );
  modport sink (
    input  valid, alu_slot_kind, alu_slot_pc, alu_slot_src_a, alu_slot_src_b,
           alu_slot_dest, mem_slot_kind, mem_slot_pc, mem_slot_src_a,
           mem_slot_src_b, mem_slot_dest, consumed,
    output ready
  );
endinterface

FILE: rtl/dihu_pack_logic.sv
// combinational packing, steering, squash and load-use decision for one cycle
// depends on dihu_pkg
module dihu_pack_logic import dihu_pkg::*; (
  input  logic       warming_up,
  input  slot_t      alu,
  input  slot_t      mem,
  input  slot_t      pf0,
  input  slot_t      pf1,
  input  slot_t      cand0,
  input  slot_t      cand1,
  output slot_t      pack_alu_next,
  output slot_t      pack_mem_next,
  output slot_t      pf0_next,
  output slot_t      pf1_next,
  output logic [1:0] consumed
);

  logic squash;

  assign squash = is_jump(alu) ||
                  ((alu.kind == K_BRANCH) && (alu.pc != (pf0.pc - BRANCH_STEP)));

  always_comb begin
    pack_alu_next = alu;
    pack_mem_next = mem;
    pf0_next      = pf0;
    pf1_next      = pf1;
    consumed      = 2'd0;
    if (warming_up) begin
      pf0_next = cand0;
      pf1_next = cand1;
      consumed = 2'd2;
    end else begin
      if (squash) begin
        pack_alu_next = SQUASH_SLOT;
        pack_mem_next = SQUASH_SLOT;
      end else if (is_mem(pf0)) begin
        pack_mem_next = pf0;
        consumed      = 2'd1;
        if (is_mem(pf1) || pair_hazard(pf0, pf1)) begin
          pack_alu_next = NOP_SLOT;
        end else begin
          pack_alu_next = pf1;
          consumed      = 2'd2;
        end
      end else begin
        pack_alu_next = pf0;
        consumed      = 2'd1;
        if ((pf0.kind == K_BRANCH) || is_jump(pf0)) begin
          pack_mem_next = NOP_SLOT;
        end else if (!pair_hazard(pf0, pf1) && is_mem(pf1)) begin
          pack_mem_next = pf1;
          consumed      = 2'd2;
        end else begin
          pack_mem_next = NOP_SLOT;
        end
      end

      // load in the packing memory slot stalls dependent consumers
      if (mem.kind == K_LOAD) begin
        if ((consumed != 2'd0) && load_use(mem, pf0)) begin
          pack_alu_next = NOP_SLOT;
          pack_mem_next = NOP_SLOT;
          consumed      = 2'd0;
        end else if ((consumed == 2'd2) && load_use(mem, pf1)) begin
          if (is_mem(pf1)) begin
            pack_mem_next = NOP_SLOT;
          end else begin
            pack_alu_next = NOP_SLOT;
          end
          consumed = 2'd1;
        end
      end

      if (consumed == 2'd1) begin
        pf0_next = pf1;
        pf1_next = cand0;
      end else if (consumed == 2'd2) begin
        pf0_next = cand0;
        pf1_next = cand1;
      end
    end
  end

endmodule

FILE: rtl/dual_issue_packing_hazard_unit.sv
// top level of the dual-issue packing and hazard unit
// depends on dihu_pkg, dihu_if and dihu_pack_logic
// a pair waits in the packing register until the next transfer moves it to the output
// throughput: one transfer per cycle unless a held result is not taken; the output
// register lets a new transfer in while the previous result is taken in the same cycle
// reset (synchronous): prefetch buffer and packing slots to no-ops, warm-up pending,
// output register empty
module dual_issue_packing_hazard_unit import dihu_pkg::*; (
  input logic       clk,
  input logic       rst,
  dihu_in_if.sink   instr,
  dihu_out_if.source issue
);

  // architectural state
  slot_t pf0;
  slot_t pf1;
  slot_t pack_alu;
  slot_t pack_mem;
  logic  warming_up;

  // result register
  logic       out_valid;
  slot_t      out_alu;
  slot_t      out_mem;
  logic [1:0] out_consumed;

  slot_t      cand0;
  slot_t      cand1;
  slot_t      pack_alu_next;
  slot_t      pack_mem_next;
  slot_t      pf0_next;
  slot_t      pf1_next;
  logic [1:0] consumed_next;
  logic       in_xfer;

  // accept whenever the result register is empty or being drained this cycle
  assign instr.ready = !out_valid || issue.ready;
  assign in_xfer     = instr.valid && instr.ready;

  // offered pair, pc held modulo the internal pc width
  assign cand0 = '{kind: instr.first_kind, pc: PC_BITS'(instr.first_pc),
                   src_a: instr.first_src_a, src_b: instr.first_src_b,
                   dest: instr.first_dest};
  assign cand1 = '{kind: instr.second_kind, pc: PC_BITS'(instr.second_pc),
                   src_a: instr.second_src_a, src_b: instr.second_src_b,
                   dest: instr.second_dest};

  dihu_pack_logic u_pack (
    .warming_up    (warming_up),
    .alu           (pack_alu),
    .mem           (pack_mem),
    .pf0           (pf0),
    .pf1           (pf1),
    .cand0         (cand0),
    .cand1         (cand1),
    .pack_alu_next (pack_alu_next),
    .pack_mem_next (pack_mem_next),
    .pf0_next      (pf0_next),
    .pf1_next      (pf1_next),
    .consumed      (consumed_next)
  );

  // state advances once per accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      pf0        <= NOP_SLOT;
      pf1        <= NOP_SLOT;
      pack_alu   <= NOP_SLOT;
      pack_mem   <= NOP_SLOT;
      warming_up <= 1'b1;
    end else if (in_xfer) begin
      pf0        <= pf0_next;
      pf1        <= pf1_next;
      pack_alu   <= pack_alu_next;
      pack_mem   <= pack_mem_next;
      warming_up <= 1'b0;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (issue.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload: the pair leaving the packing register moves into the output register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_alu      <= pack_alu;
      out_mem      <= pack_mem;
      out_consumed <= consumed_next;
    end
  end

  assign issue.valid          = out_valid;
  assign issue.alu_slot_kind  = out_alu.kind;
  assign issue.alu_slot_pc    = 32'(out_alu.pc);
  assign issue.alu_slot_src_a = out_alu.src_a;
  assign issue.alu_slot_src_b = out_alu.src_b;
  assign issue.alu_slot_dest  = out_alu.dest;
  assign issue.mem_slot_kind  = out_mem.kind;
  assign issue.mem_slot_pc    = 32'(out_mem.pc);
  assign issue.mem_slot_src_a = out_mem.src_a;
  assign issue.mem_slot_src_b = out_mem.src_b;
  assign issue.mem_slot_dest  = out_mem.dest;
  assign issue.consumed       = out_consumed;

endmodule
